// ===== sv/mstp_pkg.sv =====
// Shared types and constants for the Prim spanning tree block.
`default_nettype none

package mstp_pkg;

   localparam int DEF_MAX_VERTICES = 16;

   localparam int VERTEX_W    = 5;
   localparam int COST_W      = 10;
   localparam int TOTAL_W     = 14;
   localparam int ACTION_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;

   localparam logic [COST_W-1:0]   NO_EDGE   = 10'd999;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX = 14'd16383;
   localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 5'd16;
   localparam logic [VERTEX_W-1:0] SOURCE_RESET = 5'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE       = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_SOLVE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_A,
      ST_ADD_B,
      ST_START,
      ST_RELAX,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } state_type;

   // one entry of the per-vertex table
   typedef struct packed {
      logic [VERTEX_W-1:0] parent;
      logic [COST_W-1:0]   weight;
   } node_type;

endpackage

`default_nettype wire

// ===== sv/mstp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mstp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/minimum_spanning_tree_prim.sv =====
// Prim minimum spanning tree over a dense cost matrix, one shared relax/compare unit.
// Steps: clear writes no-edge to every matrix entry, add edge writes both mirrored entries,
// solve scans a matrix row per joined vertex, then emits each row and holds it until taken.
// Throughput: one beat at a time; req_tready is high only while idle. The single edge RAM
// read port, one matrix entry per cycle, sets the solve time.
// Reset: synchronous; afterwards a clearing pass fills the whole matrix with no-edge
// before the first beat is taken.
`default_nettype none

module minimum_spanning_tree_prim #(
   parameter int MAX_VERTICES = mstp_pkg::DEF_MAX_VERTICES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = vertex_a[4:0], vertex_b[9:5], edge_cost[19:10], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mstp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: tuser = action[1:0]
   input  logic [mstp_pkg::ACTION_W-1:0]       req_tuser,
   // response: tdata = vertex_number[4:0], in_tree[5], tree_distance[15:6],
   //           parent_vertex[20:16], total_cost[34:21], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mstp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // register writes
   input  logic                                csr_we,
   input  logic [mstp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mstp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import mstp_pkg::*;

   localparam int VIDX_W     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int EDGE_AW    = 2 * VIDX_W;
   localparam int EDGE_DEPTH = 1 << EDGE_AW;
   localparam int NODE_W     = $bits(node_type);

   // sequencer
   state_type state_ff, state_in;
   logic [EDGE_AW-1:0] sweep_ff, sweep_in;

   // configuration
   logic [VERTEX_W-1:0] vcount_ff, vcount_in;
   logic [VERTEX_W-1:0] src_ff, src_in;

   // current job
   logic [VCNT_W-1:0] n_ff, n_in;
   logic [VIDX_W-1:0] edge_a_ff, edge_a_in;
   logic [VIDX_W-1:0] edge_b_ff, edge_b_in;
   logic [COST_W-1:0] cost_ff, cost_in;

   // relax pass
   logic [VIDX_W-1:0] pick_ff, pick_in;
   logic [VIDX_W-1:0] rd_i_ff, rd_i_in;
   logic              issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [VIDX_W-1:0] cmp_i_ff, cmp_i_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic              found_ff, found_in;
   logic [VIDX_W-1:0] next_pick_ff, next_pick_in;
   logic [MAX_VERTICES-1:0] known_ff, known_in;
   logic [MAX_VERTICES-1:0] touched_ff, touched_in;   // table entry written this solve

   // row output
   logic [VIDX_W-1:0]   out_i_ff, out_i_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [VERTEX_W-1:0] rsp_vnum_ff, rsp_vnum_in;
   logic                rsp_in_tree_ff, rsp_in_tree_in;
   logic [COST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [VERTEX_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic                rsp_last_ff, rsp_last_in;

   // memories
   logic               edge_we;
   logic [EDGE_AW-1:0] edge_waddr;
   logic [COST_W-1:0]  edge_wdata;
   logic [EDGE_AW-1:0] edge_raddr;
   logic [COST_W-1:0]  edge_rdata;
   logic               node_we;
   logic [VIDX_W-1:0]  node_waddr;
   node_type           node_wdata;
   logic [VIDX_W-1:0]  node_raddr;
   logic [NODE_W-1:0]  node_rdata;

   // helpers
   logic [VIDX_W-1:0]   last_idx;
   logic [VIDX_W-1:0]   src_idx;
   logic                src_ok;
   logic [VCNT_W-1:0]   used_n;
   logic [VERTEX_W-1:0] req_a;
   logic [VERTEX_W-1:0] req_b;
   logic [COST_W-1:0]   req_cost;
   logic                ends_ok;
   node_type            empty_node;
   node_type            cur_node;
   logic                cur_known;
   logic                upd;
   logic [COST_W-1:0]   new_dist;
   logic                take_cur;
   logic                round_found;
   logic [VIDX_W-1:0]   round_pick;
   logic [VERTEX_W-1:0] pick_parent;
   node_type            emit_node;
   logic [TOTAL_W:0]    sum;

   mstp_ram #(.WIDTH(COST_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   mstp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_VERTICES)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   assign req_a    = req_tdata[4:0];
   assign req_b    = req_tdata[9:5];
   assign req_cost = req_tdata[19:10];
   assign ends_ok  = (req_a != '0) && (32'(req_a) <= MAX_VERTICES)
                  && (req_b != '0) && (32'(req_b) <= MAX_VERTICES);

   // vertex count clamped to 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         used_n = VCNT_W'(1);
      end else if (32'(vcount_ff) > MAX_VERTICES) begin
         used_n = VCNT_W'(MAX_VERTICES);
      end else begin
         used_n = VCNT_W'(vcount_ff);
      end
   end

   assign last_idx    = VIDX_W'(n_ff - 1'b1);
   assign src_ok      = (src_ff != '0) && (32'(src_ff) <= 32'(n_ff));
   assign src_idx     = VIDX_W'(src_ff - 1'b1);
   assign pick_parent = VERTEX_W'({1'b0, pick_ff} + 1'b1);
   assign empty_node  = '{parent: '0, weight: NO_EDGE};

   // compare stage of the relax pass: matrix entry and table entry of cmp_i
   assign cur_node    = touched_ff[cmp_i_ff] ? node_type'(node_rdata) : empty_node;
   assign cur_known   = known_ff[cmp_i_ff];
   assign upd         = !cur_known && (edge_rdata < cur_node.weight);
   assign new_dist    = upd ? edge_rdata : cur_node.weight;
   // strict less keeps the lowest index on ties; this is next round's selection
   assign take_cur    = !cur_known && (new_dist < best_ff);
   assign round_found = found_ff || take_cur;
   assign round_pick  = take_cur ? cmp_i_ff : next_pick_ff;

   assign emit_node = touched_ff[out_i_ff] ? node_type'(node_rdata) : empty_node;
   assign sum       = {1'b0, total_ff} + (TOTAL_W + 1)'(emit_node.weight);

   assign edge_raddr = {pick_ff, rd_i_ff};
   assign node_raddr = (state_ff == ST_EMIT_RD) ? out_i_ff : rd_i_ff;

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      vcount_in      = vcount_ff;
      src_in         = src_ff;
      n_in           = n_ff;
      edge_a_in      = edge_a_ff;
      edge_b_in      = edge_b_ff;
      cost_in        = cost_ff;
      pick_in        = pick_ff;
      rd_i_in        = rd_i_ff;
      issue_in       = issue_ff;
      cmp_valid_in   = 1'b0;
      cmp_i_in       = cmp_i_ff;
      best_in        = best_ff;
      found_in       = found_ff;
      next_pick_in   = next_pick_ff;
      known_in       = known_ff;
      touched_in     = touched_ff;
      out_i_in       = out_i_ff;
      total_in       = total_ff;
      rsp_vnum_in    = rsp_vnum_ff;
      rsp_in_tree_in = rsp_in_tree_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_last_in    = rsp_last_ff;
      edge_we        = 1'b0;
      edge_waddr     = sweep_ff;
      edge_wdata     = NO_EDGE;
      node_we        = 1'b0;
      node_waddr     = cmp_i_ff;
      node_wdata     = '{parent: pick_parent, weight: edge_rdata};

      if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wdata;
            CSR_SOURCE:       src_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            edge_we = 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (action_type'(req_tuser))
                  ACT_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_ADD: begin
                     if (ends_ok) begin
                        edge_a_in = VIDX_W'(req_a - 1'b1);
                        edge_b_in = VIDX_W'(req_b - 1'b1);
                        cost_in   = (req_cost > NO_EDGE) ? NO_EDGE : req_cost;
                        state_in  = ST_ADD_A;
                     end
                  end
                  ACT_SOLVE: begin
                     n_in     = used_n;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_A: begin
            edge_we    = 1'b1;
            edge_waddr = {edge_a_ff, edge_b_ff};
            edge_wdata = cost_ff;
            state_in   = ST_ADD_B;
         end
         ST_ADD_B: begin
            edge_we    = 1'b1;
            edge_waddr = {edge_b_ff, edge_a_ff};
            edge_wdata = cost_ff;
            state_in   = ST_IDLE;
         end
         ST_START: begin
            total_in   = '0;
            out_i_in   = '0;
            known_in   = '0;
            touched_in = '0;
            if (src_ok) begin
               // source joins first at distance zero
               known_in[src_idx]   = 1'b1;
               touched_in[src_idx] = 1'b1;
               node_we    = 1'b1;
               node_waddr = src_idx;
               node_wdata = '{parent: '0, weight: '0};
               pick_in    = src_idx;
               rd_i_in    = '0;
               issue_in   = 1'b1;
               best_in    = NO_EDGE;
               found_in   = 1'b0;
               state_in   = ST_RELAX;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_RELAX: begin
            // read issue
            cmp_valid_in = issue_ff;
            cmp_i_in     = rd_i_ff;
            if (issue_ff) begin
               if (rd_i_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  rd_i_in = rd_i_ff + 1'b1;
               end
            end
            // compare and update
            if (cmp_valid_ff) begin
               if (upd) begin
                  node_we              = 1'b1;
                  touched_in[cmp_i_ff] = 1'b1;
               end
               if (take_cur) begin
                  best_in      = new_dist;
                  next_pick_in = cmp_i_ff;
                  found_in     = 1'b1;
               end
               if (cmp_i_ff == last_idx) begin
                  if (round_found) begin
                     pick_in              = round_pick;
                     known_in[round_pick] = 1'b1;
                     rd_i_in              = '0;
                     issue_in             = 1'b1;
                     best_in              = NO_EDGE;
                     found_in             = 1'b0;
                  end else begin
                     state_in = ST_EMIT_RD;
                  end
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_vnum_in    = VERTEX_W'({1'b0, out_i_ff} + 1'b1);
            rsp_in_tree_in = known_ff[out_i_ff];
            rsp_dist_in    = emit_node.weight;
            rsp_parent_in  = emit_node.parent;
            rsp_last_in    = (out_i_ff == last_idx);
            if (known_ff[out_i_ff]) begin
               total_in = (sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               if (out_i_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  out_i_in = out_i_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         vcount_ff    <= VCOUNT_RESET;
         src_ff       <= SOURCE_RESET;
         issue_ff     <= 1'b0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         known_ff     <= '0;
         touched_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         vcount_ff    <= vcount_in;
         src_ff       <= src_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         known_ff     <= known_in;
         touched_ff   <= touched_in;
      end
      n_ff           <= n_in;
      edge_a_ff      <= edge_a_in;
      edge_b_ff      <= edge_b_in;
      cost_ff        <= cost_in;
      pick_ff        <= pick_in;
      rd_i_ff        <= rd_i_in;
      cmp_i_ff       <= cmp_i_in;
      best_ff        <= best_in;
      next_pick_ff   <= next_pick_in;
      out_i_ff       <= out_i_in;
      total_ff       <= total_in;
      rsp_vnum_ff    <= rsp_vnum_in;
      rsp_in_tree_ff <= rsp_in_tree_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT_WAIT);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, total_ff, rsp_parent_ff, rsp_dist_ff, rsp_in_tree_ff, rsp_vnum_ff};

   // no request beat is taken while a row is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a row is pending");

   // the vertex being relaxed from has already joined the tree
   a_pick_known: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> known_ff[pick_ff])
      else $error("relaxing from a vertex not in the tree");

   // a relax update never touches a vertex already in the tree
   a_upd_unknown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX && node_we) |-> !known_ff[node_waddr])
      else $error("distance of a joined vertex changed");

   // the last row hands control straight back to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after last row");

endmodule

`default_nettype wire
